// File: sv/rau_pkg.sv
// Shared types, op codes and constants for the rational arithmetic unit.
package rau_pkg;

	localparam int WIDTH = 32;

	// magnitude bound for a reduced result: 2^(WIDTH-1)
	localparam logic [63:0] LIM = 64'(1) << (WIDTH - 1);

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_LT  = 3'd4;
	localparam logic [2:0] OP_EQ  = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVF      = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_X,
		S_MUL_Y,
		S_MUL_D,
		S_CAP_D,
		S_EVAL,
		S_GCD,
		S_DIV_N,
		S_DIV_D,
		S_CHECK
	} seq_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// File: sv/rational_arithmetic_unit.sv
// Top level: sequencer around a shared multiplier, a GCD unit and a divider.
//
// Usage: drive op and both fractions with start high while busy is low; the
// item is taken at that clock edge and busy rises in the next cycle.
// One result follows per item, shown on res_num, res_den, is_less, is_equal
// and status for exactly one cycle with done high; the receiver cannot stall
// and must take it then. busy is already low in the done cycle, so the next
// item may be started there.
// Compare and pass-through ops finish after the products and evaluation, as do
// arithmetic ops with a zero numerator or zero denominator. Reduced arithmetic
// ops go on from evaluation through the binary GCD steps, two divisions by the
// GCD and a check state. The binary GCD loop and the bit-serial divider take
// the bulk of their time. Items are worked one at a time.
// Reset: arst_n clears the sequencer, busy and done at once; an item in flight
// is dropped, none is emitted across reset and no clearing pass is needed.
module rational_arithmetic_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [31:0] a_num,
	input  logic [30:0]        a_den,
	input  logic signed [31:0] b_num,
	input  logic [30:0]        b_den,
	output logic               done,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic               is_less,
	output logic               is_equal,
	output logic [1:0]         status
);
	import rau_pkg::*;

	seq_state_t state_q, state_d;

	logic [2:0]         op_q;
	logic signed [31:0] an_q, bn_q;
	logic [30:0]        ad_q, bd_q;
	logic signed [63:0] x_q, y_q;
	logic [63:0]        den_q, nmag_q, g_q;
	logic               neg_q, done_q;

	logic signed [32:0] mul_a, mul_b, bn_ext, bn_abs;
	logic signed [63:0] prod;
	logic signed [63:0] s;
	logic               s_neg;
	logic [63:0]        s_mag;

	logic        gcd_go, div_go, fin;
	logic [63:0] gcd_g, div_q, div_dvd, div_dsr;
	unit_stat_t  gcd_st, div_st;

	logic signed [31:0] fin_num;
	logic [30:0]        fin_den;
	logic               fin_lt, fin_eq;
	logic [1:0]         fin_st;
	logic               ovf;

	// operand select for the shared multiplier
	assign bn_ext = {bn_q[31], bn_q};
	assign bn_abs = bn_q[31] ? -bn_ext : bn_ext;

	always_comb begin
		mul_a = {an_q[31], an_q};
		mul_b = {2'b00, bd_q};
		unique case (state_q)
			S_MUL_X: begin
				mul_a = {an_q[31], an_q};
				mul_b = (op_q == OP_MUL) ? bn_ext : {2'b00, bd_q};
			end
			S_MUL_Y: begin
				mul_a = bn_ext;
				mul_b = {2'b00, ad_q};
			end
			S_MUL_D: begin
				mul_a = {2'b00, ad_q};
				mul_b = (op_q == OP_DIV) ? bn_abs : {2'b00, bd_q};
			end
			default: begin
				mul_a = {an_q[31], an_q};
				mul_b = {2'b00, bd_q};
			end
		endcase
	end

	rau_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	// exact numerator and its sign
	always_comb begin
		unique case (op_q)
			OP_ADD:  s = x_q + y_q;
			OP_SUB:  s = x_q - y_q;
			default: s = x_q;
		endcase
		s_neg = (op_q == OP_DIV) ? (x_q < 0) != bn_q[31] : s < 0;
		s_mag = s[63] ? 64'(-s) : 64'(s);
	end

	rau_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_go),
		.u      (s_mag),
		.v      (den_q),
		.g_q    (gcd_g),
		.stat   (gcd_st)
	);

	assign div_dvd = (state_q == S_GCD) ? nmag_q : den_q;
	assign div_dsr = (state_q == S_GCD) ? gcd_g : g_q;

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quot     (div_q),
		.stat     (div_st)
	);

	// range check of the reduced result
	assign ovf = den_q > LIM - 64'd1 || (neg_q ? nmag_q > LIM : nmag_q > LIM - 64'd1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and result select
	always_comb begin
		state_d = state_q;
		gcd_go  = 1'b0;
		div_go  = 1'b0;
		fin     = 1'b0;
		fin_num = '0;
		fin_den = 31'd1;
		fin_lt  = 1'b0;
		fin_eq  = 1'b0;
		fin_st  = ST_OK;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_MUL_X;
			S_MUL_X: state_d = S_MUL_Y;
			S_MUL_Y: state_d = S_MUL_D;
			S_MUL_D: state_d = S_CAP_D;
			S_CAP_D: state_d = S_EVAL;
			S_EVAL: begin
				if (op_q == OP_LT || op_q == OP_EQ || op_q > OP_EQ) begin
					fin     = 1'b1;
					fin_num = an_q;
					fin_den = ad_q;
					fin_lt  = (op_q == OP_LT || op_q == OP_EQ) && x_q < y_q;
					fin_eq  = (op_q == OP_LT || op_q == OP_EQ) && x_q == y_q;
					state_d = S_IDLE;
				end else if (den_q == 64'd0) begin
					fin     = 1'b1;
					fin_st  = ST_ZERO_DEN;
					state_d = S_IDLE;
				end else if (s_mag == 64'd0) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					gcd_go  = 1'b1;
					state_d = S_GCD;
				end
			end
			S_GCD: begin
				if (gcd_st.done) begin
					div_go  = 1'b1;
					state_d = S_DIV_N;
				end
			end
			S_DIV_N: begin
				if (div_st.done) begin
					div_go  = 1'b1;
					state_d = S_DIV_D;
				end
			end
			S_DIV_D: if (div_st.done) state_d = S_CHECK;
			S_CHECK: begin
				fin     = 1'b1;
				state_d = S_IDLE;
				if (ovf) begin
					fin_st = ST_OVF;
				end else begin
					fin_num = neg_q ? -nmag_q[31:0] : nmag_q[31:0];
					fin_den = den_q[30:0];
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// operand capture and working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q <= op;
					an_q <= a_num;
					ad_q <= a_den;
					bn_q <= b_num;
					bd_q <= b_den;
				end
			end
			S_MUL_Y: x_q   <= prod;
			S_MUL_D: y_q   <= prod;
			S_CAP_D: den_q <= 64'(prod);
			S_EVAL: begin
				nmag_q <= s_mag;
				neg_q  <= s_neg;
			end
			S_GCD:   if (gcd_st.done) g_q <= gcd_g;
			S_DIV_N: if (div_st.done) nmag_q <= div_q;
			S_DIV_D: if (div_st.done) den_q <= div_q;
			default: begin
			end
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	// hold the result for its cycle
	always_ff @(posedge clk) begin
		if (fin) begin
			res_num  <= fin_num;
			res_den  <= fin_den;
			is_less  <= fin_lt;
			is_equal <= fin_eq;
			status   <= fin_st;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item taken but not busy");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3) else $error("bad status code");
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> res_num == 32'sd0 && res_den == 31'd1)
		else $error("faulted result not zero over one");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_less && is_equal)) else $error("less and equal both set");
`endif
endmodule

// File: sv/rau_mul.sv
// Registered signed 33 x 33 multiplier shared by all product steps.
module rau_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [63:0] p_q
);
	logic signed [65:0] prod;

	// form the full product, keep the low 64 bits
	assign prod = a * b;

	always_ff @(posedge clk) begin
		p_q <= prod[63:0];
	end
endmodule

// File: sv/rau_gcd.sv
// Binary GCD unit: one shift or subtract step per cycle over 64-bit values.
module rau_gcd (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       u,
	input  logic [63:0]       v,
	output logic [63:0]       g_q,
	output rau_pkg::unit_stat_t stat
);
	import rau_pkg::*;

	logic [63:0] u_q, v_q;
	logic [5:0]  k_q;
	logic        common_q;
	logic        busy_q, done_q;
	logic [64:0] diff;

	// one compare and subtract for the u >= v order; the other order subtracts apart
	assign diff = {1'b0, u_q} - {1'b0, v_q};

	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && !common_q && u_q[0] && v_q[0] && diff == 65'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath: strip common twos, then reduce by shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			u_q      <= u;
			v_q      <= v;
			k_q      <= '0;
			common_q <= 1'b1;
		end else if (busy_q) begin
			if (common_q) begin
				if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 6'd1;
				end else begin
					common_q <= 1'b0;
				end
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (diff == 65'd0) begin
				g_q <= u_q << k_q;
			end else if (!diff[64]) begin
				u_q <= diff[63:0];
			end else begin
				v_q <= v_q - u_q;
			end
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("gcd done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("gcd not busy after start");
	a_done_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && $past(u_q) != 64'd0 |-> g_q != 64'd0) else $error("gcd zero");
`endif
endmodule

// File: sv/rau_div.sv
// Restoring divider: one quotient bit per cycle, 64-bit dividend and divisor.
module rau_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       dividend,
	input  logic [63:0]       divisor,
	output logic [63:0]       quot,
	output rau_pkg::unit_stat_t stat
);
	import rau_pkg::*;

	logic [63:0] dvd_q, dsr_q, rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] sh, trial;

	// shift in the next dividend bit and try the subtract
	assign sh    = {rem_q, dvd_q[63]};
	assign trial = sh - {1'b0, dsr_q};

	assign quot      = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				dvd_q <= {dvd_q[62:0], 1'b1};
			end else begin
				rem_q <= sh[63:0];
				dvd_q <= {dvd_q[62:0], 1'b0};
			end
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != 7'd0) else $error("divider count ran out");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |-> rem_q < dsr_q) else $error("remainder not below divisor");
`endif
endmodule

// File: tb/testbench.sv
// Self-checking testbench for the rational arithmetic unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rau_pkg::*;

	localparam int N_RANDOM   = 500;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic               lt;
		logic               eq;
		logic [1:0]         st;
	} fraction_res_t;

	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] an;
		logic [30:0]        ad;
		logic signed [31:0] bn;
		logic [30:0]        bd;
		bit                 fixed;
		fraction_res_t      res;
	} stim_row_t;

	logic clk, arst_n, start, busy, done;
	logic [2:0] op;
	logic signed [31:0] a_num, b_num, res_num;
	logic [30:0] a_den, b_den, res_den;
	logic is_less, is_equal;
	logic [1:0] status;

	fraction_res_t pending_q[$];
	int mismatches = 0;
	int idle_cycles = 0;

	rational_arithmetic_unit u_dut (.*);

	// free-running clock
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] abs64(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// work out the exact reduced result of one item
	function automatic fraction_res_t predict_fraction(logic [2:0] o,
			logic signed [31:0] an, logic [30:0] ad,
			logic signed [31:0] bn, logic [30:0] bd);
		fraction_res_t r;
		logic signed [63:0] x, y, s;
		logic [63:0] nmag, dn, g;
		bit neg;
		r = '{num: an, den: ad, lt: 0, eq: 0, st: ST_OK};
		x = 64'(an) * $signed({33'd0, bd});
		y = 64'(bn) * $signed({33'd0, ad});
		case (o)
			OP_ADD, OP_SUB: begin
				s = (o == OP_ADD) ? x + y : x - y;
				neg = s < 0;
				nmag = abs64(s);
				dn = 64'(ad) * 64'(bd);
			end
			OP_MUL: begin
				s = 64'(an) * 64'(bn);
				neg = s < 0;
				nmag = abs64(s);
				dn = 64'(ad) * 64'(bd);
			end
			OP_DIV: begin
				neg = (x < 0) != (bn < 0);
				nmag = abs64(x);
				dn = 64'(ad) * abs64(64'(bn));
			end
			OP_LT, OP_EQ: begin
				r.lt = x < y;
				r.eq = x == y;
				return r;
			end
			default: return r;
		endcase
		r = '{num: 0, den: 1, lt: 0, eq: 0, st: ST_OK};
		if (dn == 0) begin
			r.st = ST_ZERO_DEN;
			return r;
		end
		if (nmag == 0) return r;
		g = gcd_of(nmag, dn);
		nmag = nmag / g;
		dn = dn / g;
		if (dn > LIM - 1 || (neg ? nmag > LIM : nmag > LIM - 1)) begin
			r.st = ST_OVF;
			return r;
		end
		r.num = neg ? -nmag[31:0] : nmag[31:0];
		r.den = dn[30:0];
		return r;
	endfunction

	// hold start until the item is taken; start stays high into the next item unless an idle gap is drawn
	task automatic send_item(logic [2:0] o, logic signed [31:0] an, logic [30:0] ad,
			logic signed [31:0] bn, logic [30:0] bd, bit fixed, fraction_res_t fr,
			bit may_idle);
		fraction_res_t exp_r;
		if (may_idle && $urandom_range(99) < 7) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1;
		op <= o;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		@(posedge clk);
		while (busy) @(posedge clk);
		exp_r = fixed ? fr : predict_fraction(o, an, ad, bn, bd);
		pending_q = {pending_q, exp_r};
	endtask

	function automatic logic signed [31:0] rand_num();
		case ($urandom_range(4))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($signed($urandom_range(0, 40)) - 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rand_den();
		case ($urandom_range(4))
			0: return 31'h7fffffff;
			1: return 1;
			2: return 31'($urandom_range(1, 60));
			default: return 31'($urandom) | 31'd1;
		endcase
	endfunction

	// check each result against the oldest expectation
	always @(posedge clk) begin
		fraction_res_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result with none expected: %0d/%0d", $time,
					res_num, res_den);
				mismatches++;
			end else begin
				e = pending_q.pop_front();
				if (res_num !== e.num || res_den !== e.den || is_less !== e.lt ||
						is_equal !== e.eq || status !== e.st) begin
					$display("%0t: expected %0d/%0d lt=%0b eq=%0b st=%0d, got %0d/%0d lt=%0b eq=%0b st=%0d",
						$time, e.num, e.den, e.lt, e.eq, e.st,
						res_num, res_den, is_less, is_equal, status);
					mismatches++;
				end
			end
		end
	end

	// watchdog: count cycles with nothing accepted and no result shown
	always @(posedge clk) begin
		if (done || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		fraction_res_t z;
		int k;
		start = 0; op = OP_ADD; a_num = 0; a_den = 1; b_num = 0; b_den = 1;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		z = '{num: 0, den: 1, lt: 0, eq: 0, st: ST_OK};
		// directed table; fixed rows carry a result read off directly
		rows = '{
			'{OP_ADD, 1, 2, 1, 3, 0, z},
			'{OP_SUB, 1, 2, 1, 2, 1, z},
			'{OP_MUL, 0, 5, 7, 3, 1, z},
			'{OP_DIV, 3, 4, 0, 1, 1, '{0, 1, 0, 0, ST_ZERO_DEN}},
			'{OP_ADD, 5, 0, 1, 1, 0, z},
			'{OP_DIV, 1, 2, -3, 4, 0, z},
			'{OP_LT, 1, 3, 1, 2, 1, '{1, 3, 1, 0, ST_OK}},
			'{OP_EQ, 2, 4, 1, 2, 1, '{2, 4, 0, 1, ST_OK}},
			'{OP_LT, -7, 0, 3, 0, 0, z},
			'{3'd6, -9, 5, 1, 1, 1, '{-9, 5, 0, 0, ST_OK}},
			'{3'd7, 32'sh7fffffff, 31'h7fffffff, 0, 1, 1,
				'{32'sh7fffffff, 31'h7fffffff, 0, 0, ST_OK}},
			'{OP_MUL, 32'sh80000000, 1, 32'sh80000000, 1, 1, '{0, 1, 0, 0, ST_OVF}},
			'{OP_MUL, 32'sh80000000, 1, 1, 1, 0, z},
			'{OP_MUL, 32'sh80000000, 1, -1, 1, 0, z},
			'{OP_ADD, 32'sh7fffffff, 1, 32'sh7fffffff, 1, 0, z},
			'{OP_SUB, 32'sh80000000, 1, 1, 1, 0, z},
			'{OP_DIV, 1, 31'h7fffffff, 1, 31'h7fffffff, 0, z},
			'{OP_MUL, 1, 31'h7fffffff, 1, 2, 0, z},
			'{OP_ADD, 32'sh80000000, 31'h7fffffff, 32'sh7fffffff, 31'h7ffffffe, 0, z},
			'{OP_DIV, 32'sh80000000, 3, 32'sh80000000, 3, 0, z},
			'{OP_EQ, 32'sh80000000, 31'h7fffffff, 32'sh80000000, 31'h7fffffff, 0, z}
		};
		foreach (rows[i])
			send_item(rows[i].op, rows[i].an, rows[i].ad, rows[i].bn, rows[i].bd,
				rows[i].fixed, rows[i].res, 1);
		// random items; a run of idle-free items in the middle
		for (k = 0; k < N_RANDOM; k++) begin
			send_item(3'($urandom_range(9) < 8 ? $urandom_range(3) : $urandom_range(7)),
				rand_num(), rand_den(), rand_num(),
				($urandom_range(29) == 0) ? 31'd0 : rand_den(), 0, z,
				!(k >= 150 && k < 250));
		end
		start <= 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
